/* rtl/bsb_pkg.sv */
// ----------------------------------------------------------------------------
// bsb_pkg - shared types and constants for block-sum binning
// Configuration layout, register indexes and the front-to-back op record.
// ----------------------------------------------------------------------------
`default_nettype none

package bsb_pkg;

   // Default geometry parameters
   localparam int MAX_WIDTH_DEF    = 4096;
   localparam int MAX_CELL_DIM_DEF = 256;

   // Field widths fixed by the interface
   localparam int PIXEL_W   = 8;
   localparam int SUM_W     = 24;
   localparam int CELL_COL_W = 12;
   localparam int ROW_W     = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_WIDTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_HEIGHT  = 3'd3;

   localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd1024;
   localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd1024;
   localparam logic [8:0]  CELL_WIDTH_RST   = 9'd16;
   localparam logic [8:0]  CELL_HEIGHT_RST  = 9'd16;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [12:0] image_width;
      logic [15:0] image_height;
      logic [8:0]  cell_width;
      logic [8:0]  cell_height;
   } cfg_type;

   // One finished cell segment, handed from front to back
   typedef struct packed {
      logic [SUM_W-1:0] seg_sum;    // pixels of this segment
      logic [ROW_W-1:0] band;       // cell row index
      logic             first_row;  // first row of band: no prior sum
      logic             band_end;   // last row of band: emit instead of store
      logic             row_end;    // last cell of the cell row
      logic             tile_end;   // last cell of the tile
   } op_type;

endpackage

`default_nettype wire

/* rtl/bsb_queue.sv */
// ----------------------------------------------------------------------------
// bsb_queue - small FIFO between front and back
// Register-based queue, head always visible; user must block push when full.
// ----------------------------------------------------------------------------
`default_nettype none

module bsb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bsb_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  not_full,
   input  wire logic             pop,
   output logic                  head_valid,
   output logic [WIDTH-1:0]      head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign not_full   = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/bsb_front.sv */
// ----------------------------------------------------------------------------
// bsb_front - pixel counters and cell classification
// Tracks raster position, adds pixels into the running segment sum and
// hands one op per finished cell segment to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bsb_front #(
   parameter int MAX_WIDTH    = bsb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_CELL_DIM = bsb_pkg::MAX_CELL_DIM_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire bsb_pkg::cfg_type                 cfg,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [bsb_pkg::PIXEL_W-1:0]      req_pixel,
   input  wire logic                             q_not_full,
   output logic                                  q_push,
   output bsb_pkg::op_type                       q_op,
   output logic [$clog2(MAX_WIDTH)-1:0]          q_slot
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CD_W  = $clog2(MAX_CELL_DIM);

   logic [COL_W-1:0]            pcol_ff, pcol_in;
   logic [bsb_pkg::ROW_W-1:0]   prow_ff, prow_in;
   logic [CD_W-1:0]             cic_ff, cic_in;
   logic [CD_W-1:0]             rib_ff, rib_in;
   logic [COL_W-1:0]            cidx_ff, cidx_in;
   logic [bsb_pkg::ROW_W-1:0]   bidx_ff, bidx_in;
   logic [bsb_pkg::SUM_W-1:0]   rsum_ff, rsum_in;

   logic [31:0]                 w_lim, cw_lim, ch_lim;
   logic [COL_W-1:0]            w_m1;
   logic [CD_W-1:0]             cw_m1, ch_m1;
   logic [bsb_pkg::ROW_W-1:0]   h_m1;
   logic                        row_end, cell_end, tile_end, band_end, accept;
   logic [bsb_pkg::SUM_W-1:0]   rsum_new;

   // Clamped limits, as last positions
   always_comb begin
      w_lim = {19'd0, cfg.image_width};
      if (w_lim == 32'd0) begin
         w_lim = 32'd1;
      end else if (w_lim > 32'(MAX_WIDTH)) begin
         w_lim = 32'(MAX_WIDTH);
      end
      cw_lim = {23'd0, cfg.cell_width};
      if (cw_lim == 32'd0) begin
         cw_lim = 32'd1;
      end else if (cw_lim > 32'(MAX_CELL_DIM)) begin
         cw_lim = 32'(MAX_CELL_DIM);
      end
      ch_lim = {23'd0, cfg.cell_height};
      if (ch_lim == 32'd0) begin
         ch_lim = 32'd1;
      end else if (ch_lim > 32'(MAX_CELL_DIM)) begin
         ch_lim = 32'(MAX_CELL_DIM);
      end
      w_m1  = COL_W'(w_lim - 32'd1);
      cw_m1 = CD_W'(cw_lim - 32'd1);
      ch_m1 = CD_W'(ch_lim - 32'd1);
      h_m1  = (cfg.image_height == '0) ? '0 : cfg.image_height - 1'b1;
   end

   assign req_ready = q_not_full;
   assign accept    = req_valid && req_ready;

   // "at or past" tests so a shrunk limit ends things on the next pixel
   assign row_end  = (pcol_ff >= w_m1);
   assign cell_end = row_end || (cic_ff >= cw_m1);
   assign tile_end = (prow_ff >= h_m1);
   assign band_end = tile_end || (rib_ff >= ch_m1);
   assign rsum_new = rsum_ff + {{(bsb_pkg::SUM_W - bsb_pkg::PIXEL_W){1'b0}}, req_pixel};

   assign q_push            = accept && cell_end;
   assign q_slot            = cidx_ff;
   assign q_op.seg_sum      = rsum_new;
   assign q_op.band         = bidx_ff;
   assign q_op.first_row    = (rib_ff == '0);
   assign q_op.band_end     = band_end;
   assign q_op.row_end      = row_end;
   assign q_op.tile_end     = row_end && tile_end;

   always_comb begin
      pcol_in = pcol_ff;
      prow_in = prow_ff;
      cic_in  = cic_ff;
      rib_in  = rib_ff;
      cidx_in = cidx_ff;
      bidx_in = bidx_ff;
      rsum_in = rsum_ff;
      if (accept) begin
         if (cell_end) begin
            rsum_in = '0;
            cic_in  = '0;
            cidx_in = cidx_ff + 1'b1;
         end else begin
            rsum_in = rsum_new;
            cic_in  = cic_ff + 1'b1;
         end
         if (row_end) begin
            pcol_in = '0;
            cidx_in = '0;
            if (tile_end) begin
               prow_in = '0;
               rib_in  = '0;
               bidx_in = '0;
            end else begin
               prow_in = prow_ff + 1'b1;
               if (band_end) begin
                  rib_in  = '0;
                  bidx_in = bidx_ff + 1'b1;
               end else begin
                  rib_in = rib_ff + 1'b1;
               end
            end
         end else begin
            pcol_in = pcol_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcol_ff <= '0;
         prow_ff <= '0;
         cic_ff  <= '0;
         rib_ff  <= '0;
         cidx_ff <= '0;
         bidx_ff <= '0;
         rsum_ff <= '0;
      end else begin
         pcol_ff <= pcol_in;
         prow_ff <= prow_in;
         cic_ff  <= cic_in;
         rib_ff  <= rib_in;
         cidx_ff <= cidx_in;
         bidx_ff <= bidx_in;
         rsum_ff <= rsum_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/bsb_back.sv */
// ----------------------------------------------------------------------------
// bsb_back - band sum memory and result stage
// Reads the column's band sum, adds the segment, stores it back or emits
// the finished cell through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsb_back #(
   parameter int MAX_WIDTH = bsb_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                head_valid,
   input  wire bsb_pkg::op_type                     head_op,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]        head_slot,
   output logic                                     pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [bsb_pkg::SUM_W-1:0]                rsp_cell_sum,
   output logic [bsb_pkg::CELL_COL_W-1:0]           rsp_cell_column,
   output logic [bsb_pkg::ROW_W-1:0]                rsp_cell_row,
   output logic                                     rsp_row_done,
   output logic                                     rsp_tile_done
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [bsb_pkg::SUM_W-1:0] band_mem [MAX_WIDTH];

   logic                       b_valid_ff, b_valid_in;
   bsb_pkg::op_type            b_op_ff;
   logic [COL_W-1:0]           b_slot_ff;
   logic [bsb_pkg::SUM_W-1:0]  rd_ff;
   logic                       fwd_hit_ff;
   logic [bsb_pkg::SUM_W-1:0]  fwd_data_ff;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic [bsb_pkg::SUM_W-1:0]  prior, total;
   logic                       out_free, b_fire, b_write, b_emit;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign b_fire   = b_valid_ff && (!b_op_ff.band_end || out_free);
   assign b_write  = b_valid_ff && !b_op_ff.band_end;
   assign b_emit   = b_valid_ff && b_op_ff.band_end && out_free;
   assign pop      = head_valid && (!b_valid_ff || b_fire);

   // Store landing at the same edge as the read is bypassed
   assign prior = b_op_ff.first_row ? '0 : (fwd_hit_ff ? fwd_data_ff : rd_ff);
   assign total = prior + b_op_ff.seg_sum;

   always_comb begin
      b_valid_in = b_valid_ff;
      if (pop) begin
         b_valid_in = 1'b1;
      end else if (b_fire) begin
         b_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (b_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_op_ff     <= head_op;
         b_slot_ff   <= head_slot;
         fwd_hit_ff  <= b_write && (b_slot_ff == head_slot);
         fwd_data_ff <= total;
      end
      if (b_emit) begin
         rsp_cell_sum    <= total;
         rsp_cell_column <= bsb_pkg::CELL_COL_W'(b_slot_ff);
         rsp_cell_row    <= b_op_ff.band;
         rsp_row_done    <= b_op_ff.row_end;
         rsp_tile_done   <= b_op_ff.tile_end;
      end
   end

   // Band sum memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (b_write) begin
         band_mem[b_slot_ff] <= total;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rd_ff <= band_mem[head_slot];
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/image_block_sum_binning.sv */
// ----------------------------------------------------------------------------
// image_block_sum_binning - block-sum pooling of a grey image tile
// Sums 8-bit pixels over cells of a configured size and reports each cell.
// ----------------------------------------------------------------------------
// Pixels of one tile enter on the req_ channel in raster order, one
// transaction per pixel, and the block sustains one pixel per clock while
// the queue has room. Each cell's sum leaves on the rsp_ channel with its
// column and row index when the cell's last pixel arrives; row_done marks
// the last cell of a cell row and tile_done the last cell of the tile, after
// which all counters are back at zero. A result passes the queue, the back
// stage register and the output register. The rate is set by the front's
// position counters and by the band memory, which takes one read per
// finished cell segment and one write unless the segment ends its band.
// Cells on the right and bottom edges are partial when the sizes do not
// divide evenly; zero sizes count as one and oversized ones are clamped to
// the parameters. The band memory needs no clearing after reset, as a band's
// first row ignores it. Write csr_ registers only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module image_block_sum_binning #(
   parameter int MAX_WIDTH    = bsb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_CELL_DIM = bsb_pkg::MAX_CELL_DIM_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration writes
   input  wire logic                               csr_write,
   input  wire logic [bsb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bsb_pkg::CSR_DATA_W-1:0]     csr_data,
   // pixel channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [bsb_pkg::PIXEL_W-1:0]        req_pixel,
   // cell result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [bsb_pkg::SUM_W-1:0]               rsp_cell_sum,
   output logic [bsb_pkg::CELL_COL_W-1:0]          rsp_cell_column,
   output logic [bsb_pkg::ROW_W-1:0]               rsp_cell_row,
   output logic                                    rsp_row_done,
   output logic                                    rsp_tile_done
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int OP_W   = $bits(bsb_pkg::op_type);
   localparam int ENTRY_W = OP_W + COL_W;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   bsb_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            bsb_pkg::CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_data[12:0];
            bsb_pkg::CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_data[15:0];
            bsb_pkg::CSR_CELL_WIDTH:   cfg_in.cell_width   = csr_data[8:0];
            bsb_pkg::CSR_CELL_HEIGHT:  cfg_in.cell_height  = csr_data[8:0];
            default: ;  // unknown index: write ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= bsb_pkg::IMAGE_WIDTH_RST;
         cfg_ff.image_height <= bsb_pkg::IMAGE_HEIGHT_RST;
         cfg_ff.cell_width   <= bsb_pkg::CELL_WIDTH_RST;
         cfg_ff.cell_height  <= bsb_pkg::CELL_HEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ------------------------------------------------------------------
   // Front: counters and classification
   // ------------------------------------------------------------------
   logic             q_not_full;
   logic             q_push;
   bsb_pkg::op_type  push_op;
   logic [COL_W-1:0] push_slot;

   bsb_front #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_CELL_DIM (MAX_CELL_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_pixel  (req_pixel),
      .q_not_full (q_not_full),
      .q_push     (q_push),
      .q_op       (push_op),
      .q_slot     (push_slot)
   );

   // ------------------------------------------------------------------
   // Queue: one entry per finished cell segment
   // ------------------------------------------------------------------
   logic               q_pop;
   logic               q_head_valid;
   logic [ENTRY_W-1:0] q_head_data;
   bsb_pkg::op_type    head_op;
   logic [COL_W-1:0]   head_slot;

   bsb_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (bsb_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  ({push_slot, push_op}),
      .not_full   (q_not_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   assign head_op   = q_head_data[OP_W-1:0];
   assign head_slot = q_head_data[ENTRY_W-1:OP_W];

   // ------------------------------------------------------------------
   // Back: band sums and results
   // ------------------------------------------------------------------
   bsb_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_op         (head_op),
      .head_slot       (head_slot),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_sum    (rsp_cell_sum),
      .rsp_cell_column (rsp_cell_column),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_row_done    (rsp_row_done),
      .rsp_tile_done   (rsp_tile_done)
   );

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // the last cell of the tile is always the last of its cell row
   a_tile_implies_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tile_done |-> rsp_row_done)
      else $error("tile_done without row_done");

   // a pushed segment is visible to the back on the next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      q_push |=> q_head_valid)
      else $error("pushed segment lost in queue");

   // reset leaves no result pending and the queue empty
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && !q_head_valid)
      else $error("state left after reset");

endmodule

`default_nettype wire

/* dv/image_block_sum_binning_tb.sv */
// ----------------------------------------------------------------------------
// image_block_sum_binning_tb - self-checking bench for block-sum binning
// Streams pixel tiles of many geometries through the block, predicts every
// cell sum in a scoreboard and compares each result transaction in order.
// ----------------------------------------------------------------------------
module image_block_sum_binning_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_W       = bsb_pkg::MAX_WIDTH_DEF;
   localparam int MAX_CELL    = bsb_pkg::MAX_CELL_DIM_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int RANDOM_ITEMS = 350;
   localparam int DRAIN_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 8;     // margin for the result path to settle
   localparam int HOLD_CYCLES = 300;     // long receiver stall

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_FULL} fill_type;

   typedef struct packed {
      logic [bsb_pkg::SUM_W-1:0]      cell_sum;
      logic [bsb_pkg::CELL_COL_W-1:0] cell_column;
      logic [bsb_pkg::ROW_W-1:0]      cell_row;
      logic                           row_done;
      logic                           tile_done;
   } cell_report_type;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the registers and the binning state. Each
   // accepted pixel is folded in; a finished cell at the end of its band
   // queues one expected report.
   // -------------------------------------------------------------------------
   class cell_sum_scoreboard;
      logic [12:0]               image_width_r;
      logic [15:0]               image_height_r;
      logic [8:0]                cell_width_r;
      logic [8:0]                cell_height_r;
      logic [bsb_pkg::SUM_W-1:0] band_sum [MAX_W];
      logic [bsb_pkg::SUM_W-1:0] cell_acc;
      logic [11:0]               col_pos;
      logic [15:0]               row_pos;
      logic [7:0]                col_in_cell;
      logic [7:0]                row_in_band;
      logic [11:0]               cell_col;
      logic [15:0]               band_row;
      cell_report_type           pending_cells[$];
      int                        errors;

      function new();
         image_width_r  = bsb_pkg::IMAGE_WIDTH_RST;
         image_height_r = bsb_pkg::IMAGE_HEIGHT_RST;
         cell_width_r   = bsb_pkg::CELL_WIDTH_RST;
         cell_height_r  = bsb_pkg::CELL_HEIGHT_RST;
         foreach (band_sum[i]) band_sum[i] = '0;
         cell_acc    = '0;
         col_pos     = '0;
         row_pos     = '0;
         col_in_cell = '0;
         row_in_band = '0;
         cell_col    = '0;
         band_row    = '0;
         errors      = 0;
      endfunction

      function void write_reg(logic [bsb_pkg::CSR_INDEX_W-1:0] idx,
                              logic [bsb_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            bsb_pkg::CSR_IMAGE_WIDTH:  image_width_r  = data[12:0];
            bsb_pkg::CSR_IMAGE_HEIGHT: image_height_r = data[15:0];
            bsb_pkg::CSR_CELL_WIDTH:   cell_width_r   = data[8:0];
            bsb_pkg::CSR_CELL_HEIGHT:  cell_height_r  = data[8:0];
            default: ;  // unmapped index: no effect
         endcase
      endfunction

      function int clamp_dim(int v, int lo, int hi);
         return (v < lo) ? lo : (v > hi) ? hi : v;
      endfunction

      function bit at_tile_start();
         return col_pos == 0 && row_pos == 0;
      endfunction

      function int pending();
         return pending_cells.size();
      endfunction

      function void accumulate_pixel(logic [bsb_pkg::PIXEL_W-1:0] px);
         int                        w, h, cw, ch;
         bit                        row_end, cell_end, tile_end, band_end;
         logic [bsb_pkg::SUM_W-1:0] prior;
         logic [bsb_pkg::SUM_W-1:0] total;
         cell_report_type           rep;
         w  = clamp_dim(int'(image_width_r), 1, MAX_W);
         h  = (image_height_r == 0) ? 1 : int'(image_height_r);
         cw = clamp_dim(int'(cell_width_r), 1, MAX_CELL);
         ch = clamp_dim(int'(cell_height_r), 1, MAX_CELL);
         // boundaries use "at or past", so shrunken limits end things early
         row_end  = int'(col_pos) >= w - 1;
         cell_end = row_end || int'(col_in_cell) >= cw - 1;
         tile_end = int'(row_pos) >= h - 1;
         band_end = tile_end || int'(row_in_band) >= ch - 1;

         cell_acc = cell_acc + px;
         if (cell_end) begin
            prior = (row_in_band == 0) ? '0 : band_sum[cell_col];
            total = prior + cell_acc;
            if (band_end) begin
               rep.cell_sum    = total;
               rep.cell_column = cell_col;
               rep.cell_row    = band_row;
               rep.row_done    = row_end;
               rep.tile_done   = row_end && tile_end;
               pending_cells.push_back(rep);
            end else begin
               band_sum[cell_col] = total;
            end
            cell_acc    = '0;
            col_in_cell = '0;
            cell_col    = cell_col + 1'b1;
         end else begin
            col_in_cell = col_in_cell + 1'b1;
         end

         if (row_end) begin
            col_pos  = '0;
            cell_col = '0;
            if (tile_end) begin
               row_pos     = '0;
               row_in_band = '0;
               band_row    = '0;
            end else begin
               row_pos = row_pos + 1'b1;
               if (band_end) begin
                  row_in_band = '0;
                  band_row    = band_row + 1'b1;
               end else begin
                  row_in_band = row_in_band + 1'b1;
               end
            end
         end else begin
            col_pos = col_pos + 1'b1;
         end
      endfunction

      function void compare_field(string name, logic [bsb_pkg::SUM_W-1:0] exp_v,
                                  logic [bsb_pkg::SUM_W-1:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_cell(cell_report_type got);
         cell_report_type exp_c;
         if (pending_cells.size() == 0) begin
            $display("%0t: unexpected cell result, expected none, actual sum %0d col %0d row %0d",
                     $time, got.cell_sum, got.cell_column, got.cell_row);
            errors++;
            return;
         end
         exp_c = pending_cells.pop_front();
         compare_field("cell_sum",    exp_c.cell_sum,    got.cell_sum);
         compare_field("cell_column", exp_c.cell_column, got.cell_column);
         compare_field("cell_row",    exp_c.cell_row,    got.cell_row);
         compare_field("row_done",    exp_c.row_done,    got.row_done);
         compare_field("tile_done",   exp_c.tile_done,   got.tile_done);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT signals, driven inputs known from time zero
   // -------------------------------------------------------------------------
   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            csr_write = 1'b0;
   logic [bsb_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [bsb_pkg::CSR_DATA_W-1:0]  csr_data  = '0;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [bsb_pkg::PIXEL_W-1:0]     req_pixel = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [bsb_pkg::SUM_W-1:0]       rsp_cell_sum;
   logic [bsb_pkg::CELL_COL_W-1:0]  rsp_cell_column;
   logic [bsb_pkg::ROW_W-1:0]       rsp_cell_row;
   logic                            rsp_row_done;
   logic                            rsp_tile_done;

   cell_sum_scoreboard sb;
   int send_idle_pct = 24;
   int recv_idle_pct = 46;
   int hold_cycles   = 0;
   int items_sent    = 0;
   int cycle_count   = 0;

   image_block_sum_binning uut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_sum    (rsp_cell_sum),
      .rsp_cell_column (rsp_cell_column),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_row_done    (rsp_row_done),
      .rsp_tile_done   (rsp_tile_done)
   );

   always #10 clock = ~clock;

   // Watchdog: ends a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Monitor: transactions are taken at the rising edge, before the DUT's
   // own updates land, so input and result order is race free.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.accumulate_pixel(req_pixel);
         if (rsp_valid && rsp_ready)
            sb.check_cell({rsp_cell_sum, rsp_cell_column, rsp_cell_row,
                           rsp_row_done, rsp_tile_done});
      end
   end

   // Receiver: random back-pressure, plus a long hold-off on request so the
   // block fills and must stall its pixel input.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus tasks (all entered and left at a falling edge)
   // -------------------------------------------------------------------------
   function automatic logic [bsb_pkg::PIXEL_W-1:0] pick_pixel(fill_type fill);
      case (fill)
         FILL_ZERO: return '0;
         FILL_FULL: return '1;
         default: begin
            case ($urandom_range(0, 15))
               0:       return '0;
               1:       return '1;
               default: return bsb_pkg::PIXEL_W'($urandom_range(0, 255));
            endcase
         end
      endcase
   endfunction

   // One pixel transaction; valid stays high on return so a following pixel
   // can go back to back.
   task automatic send_pixel(logic [bsb_pkg::PIXEL_W-1:0] px);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_n(int n, fill_type fill);
      repeat (n) send_pixel(pick_pixel(fill));
   endtask

   // Runs on until the predicted counters are back at the tile origin
   task automatic run_tile(fill_type fill);
      do send_pixel(pick_pixel(fill)); while (!sb.at_tile_start());
   endtask

   // Waits for every expected cell, then for the pipeline to settle, since
   // the last pixels may not have produced a result of their own.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [bsb_pkg::CSR_INDEX_W-1:0] idx,
                                 logic [bsb_pkg::CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      sb.write_reg(idx, data);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_geometry(int w, int h, int cw, int ch);
      write_register(bsb_pkg::CSR_IMAGE_WIDTH,  bsb_pkg::CSR_DATA_W'(w));
      write_register(bsb_pkg::CSR_IMAGE_HEIGHT, bsb_pkg::CSR_DATA_W'(h));
      write_register(bsb_pkg::CSR_CELL_WIDTH,   bsb_pkg::CSR_DATA_W'(cw));
      write_register(bsb_pkg::CSR_CELL_HEIGHT,  bsb_pkg::CSR_DATA_W'(ch));
   endtask

   // Random dimension: mostly within the tile, sometimes zero, oversized
   // or past the clamp.
   function automatic int random_cell_dim(int span);
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return $urandom_range(MAX_CELL + 1, 511);
         2:       return $urandom_range(span, span + 16);
         default: return $urandom_range(1, span);
      endcase
   endfunction

   task automatic random_tile(int tile_no);
      int w, h;
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 10);
      if (tile_no == 2) begin
         // every pixel is a cell; stall the receiver to back the block up
         set_geometry(6, 6, 1, 1);
         hold_cycles = HOLD_CYCLES;
         run_tile(FILL_RANDOM);
      end else begin
         set_geometry(($urandom_range(0, 11) == 0) ? 0 : w,
                      ($urandom_range(0, 11) == 0) ? 0 : h,
                      random_cell_dim(w), random_cell_dim(h));
         if ($urandom_range(0, 5) == 0) begin
            // broken tile: cut the height short partway through
            send_n($urandom_range(1, 20), FILL_RANDOM);
            drain();
            write_register(bsb_pkg::CSR_IMAGE_HEIGHT,
                           bsb_pkg::CSR_DATA_W'($urandom_range(0, 4)));
            if (!sb.at_tile_start())
               run_tile(FILL_RANDOM);
         end else begin
            run_tile(FILL_RANDOM);
         end
      end
      drain();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int tile_no;
      int random_base;
      int waited;
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Default cell size and height: half a band of a 17-wide tile, then
      // shrink the height below the current row so the tile closes on the
      // next row.
      write_register(bsb_pkg::CSR_IMAGE_WIDTH, 16'd17);
      send_n(136, FILL_RANDOM);
      drain();
      write_register(bsb_pkg::CSR_IMAGE_HEIGHT, 16'd4);
      run_tile(FILL_RANDOM);
      drain();

      // Partial right and bottom cells with saturated and zero pixels
      set_geometry(5, 3, 2, 2);
      run_tile(FILL_FULL);
      run_tile(FILL_ZERO);
      drain();

      // Unmapped indexes must be ignored
      for (int i = bsb_pkg::CSR_CELL_HEIGHT + 1; i < (1 << bsb_pkg::CSR_INDEX_W); i++)
         write_register(bsb_pkg::CSR_INDEX_W'(i),
                        bsb_pkg::CSR_DATA_W'($urandom_range(0, 65535)));

      // Clamping: zero cell width, huge cell height.
      // Row 0 fills the band slots; row 1 reports nine single-pixel cells.
      set_geometry(9, 2, 0, 16'hFFFF);
      run_tile(FILL_RANDOM);
      drain();

      // Zero height, cell width past the clamp, partial last cell
      set_geometry(300, 0, 511, 1);
      run_tile(FILL_RANDOM);
      drain();

      // Tallest tile, cut short by a height write mid-tile
      set_geometry(4, 16'hFFFF, 2, 1);
      send_n(40, FILL_RANDOM);
      drain();
      write_register(bsb_pkg::CSR_IMAGE_HEIGHT, 16'd3);
      run_tile(FILL_RANDOM);
      drain();

      // Width reduced mid-row, column already past the new limit
      set_geometry(12, 4, 3, 2);
      send_n(18, FILL_RANDOM);
      drain();
      write_register(bsb_pkg::CSR_IMAGE_WIDTH, 16'd4);
      run_tile(FILL_RANDOM);
      drain();

      // Cell height reduced mid-band
      set_geometry(4, 6, 2, 4);
      send_n(8, FILL_RANDOM);
      drain();
      write_register(bsb_pkg::CSR_CELL_HEIGHT, 16'd1);
      run_tile(FILL_RANDOM);
      drain();

      // Random tiles in three idle phases
      random_base = items_sent;
      tile_no = 0;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         if (items_sent - random_base < RANDOM_ITEMS / 3) begin
            send_idle_pct = 24;
            recv_idle_pct = 46;
         end else if (items_sent - random_base < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 46;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         tile_no++;
         random_tile(tile_no);
      end

      // Final wait for outstanding cells, bounded
      req_valid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         if (sb.pending() != 0)
            $display("%0t: %0d expected cell results never arrived", $time, sb.pending());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
